>>> src/vcds_pkg.sv
// Shared widths, defaults and register map for the vorticity/divergence stencil.
package vcds_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int VEL_W   = 16;
    localparam int WORD_W  = 2 * VEL_W;
    localparam int DIFF_W  = VEL_W + 1;
    localparam int RES_W   = 26;
    localparam int COORD_W = 10;
    localparam int GRID_W  = 11;
    localparam int SCALE_W = 24;
    localparam int PROD_W  = DIFF_W + SCALE_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_SH = 16;
    localparam int ROUND_BIAS = 32768;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [GRID_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
    localparam logic [GRID_W-1:0]  GRID_HEIGHT_RST = 11'd1024;
    localparam logic [SCALE_W-1:0] SCALE_X_RST     = 24'd32768;
    localparam logic [SCALE_W-1:0] SCALE_Y_RST     = 24'd32768;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_SCALE_X     = 2'd2,
        REG_SCALE_Y     = 2'd3
    } t_reg_idx;

endpackage

>>> src/vcds_in_if.sv
// Velocity sample channel: one (u, v) pair per beat.
interface vcds_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [vcds_pkg::VEL_W-1:0]   u_velocity;
    logic signed [vcds_pkg::VEL_W-1:0]   v_velocity;

    modport source (output valid, output u_velocity, output v_velocity, input ready);
    modport sink   (input valid, input u_velocity, input v_velocity, output ready);
endinterface

>>> src/vcds_out_if.sv
// Result channel: vorticity, divergence and the point coordinates per beat.
interface vcds_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [vcds_pkg::RES_W-1:0]   vorticity;
    logic signed [vcds_pkg::RES_W-1:0]   divergence;
    logic [vcds_pkg::COORD_W-1:0]        column;
    logic [vcds_pkg::COORD_W-1:0]        row;
    logic                                frame_last;

    modport source (output valid, output vorticity, output divergence, output column,
                    output row, output frame_last, input ready);
    modport sink   (input valid, input vorticity, input divergence, input column,
                    input row, input frame_last, output ready);
endinterface

>>> src/vcds_ram.sv
// Generic RAM: one write port, two registered read ports, read-first.
module vcds_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Same-address read and write return the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

>>> src/velocity_curl_divergence_stencil.sv
// S1 holds the input beat; its results pass S2 and S3 into the output register S4.
// Throughput: one sample per cycle while one result or none follows it (every row but
// the last) and the output does not stall; on the last row a sample releases up to two
// results, three on the final sample, and the input waits while S1 hands them on in turn.
// Reset (synchronous, active low) restores the register defaults, zeroes the raster
// counters and empties the pipe; the line store is not cleared and needs no sweep.
module velocity_curl_divergence_stencil #(
    parameter int MAX_WIDTH  = vcds_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = vcds_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vcds_pkg::APB_AW-1:0]   paddr,
    input  logic [vcds_pkg::APB_DW-1:0]   pwdata,
    output logic [vcds_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    vcds_in_if.sink                       i_vel,
    vcds_out_if.source                    o_res
);

    // Column and row counter widths, line store geometry. Row r of the frame lives in
    // half (r & 1) of the store: one half holds the row being written, the other the
    // row above it.
    localparam int CW    = (MAX_WIDTH > 1)  ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = vcds_pkg::WORD_W;
    localparam int VW    = vcds_pkg::VEL_W;
    localparam int DW    = vcds_pkg::DIFF_W;
    localparam int PW    = vcds_pkg::PROD_W;
    localparam int SW    = vcds_pkg::SUM_W;
    localparam int GW    = vcds_pkg::GRID_W;
    localparam int KW    = vcds_pkg::SCALE_W;

    // Result jobs an input sample can release, as bit positions of the pending mask.
    // Upper: the point one row up in the same column. Trail: on the last row, the point
    // one column to the left. Corner: the final point of the frame itself.
    localparam int JOB_UPPER  = 0;
    localparam int JOB_TRAIL  = 1;
    localparam int JOB_CORNER = 2;
    localparam int NJOB       = 3;

    // ------------------------------------------------------------------
    // Configuration registers (APB, zero wait states)
    // ------------------------------------------------------------------
    logic [GW-1:0] r_grid_width;
    logic [GW-1:0] r_grid_height;
    logic [KW-1:0] r_scale_x;
    logic [KW-1:0] r_scale_y;
    logic          cfg_wr;
    logic          size_wr;
    vcds_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = vcds_pkg::t_reg_idx'(paddr[3:2]);
    assign size_wr = cfg_wr && (cfg_idx == vcds_pkg::REG_GRID_WIDTH ||
                                cfg_idx == vcds_pkg::REG_GRID_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= vcds_pkg::GRID_WIDTH_RST;
            r_grid_height <= vcds_pkg::GRID_HEIGHT_RST;
            r_scale_x     <= vcds_pkg::SCALE_X_RST;
            r_scale_y     <= vcds_pkg::SCALE_Y_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                vcds_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[GW-1:0];
                vcds_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[GW-1:0];
                vcds_pkg::REG_SCALE_X:     r_scale_x     <= pwdata[KW-1:0];
                vcds_pkg::REG_SCALE_Y:     r_scale_y     <= pwdata[KW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            vcds_pkg::REG_GRID_WIDTH:  prdata = vcds_pkg::APB_DW'(r_grid_width);
            vcds_pkg::REG_GRID_HEIGHT: prdata = vcds_pkg::APB_DW'(r_grid_height);
            vcds_pkg::REG_SCALE_X:     prdata = vcds_pkg::APB_DW'(r_scale_x);
            vcds_pkg::REG_SCALE_Y:     prdata = vcds_pkg::APB_DW'(r_scale_y);
            default:                   prdata = '0;
        endcase
    end

    // Last column and last row in use: a size of zero acts as one, an oversize
    // saturates to the maximum the store was built for.
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    always_comb begin
        if (r_grid_width == '0) begin
            w_last = '0;
        end else if (32'(r_grid_width) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_grid_width - GW'(1));
        end
        if (r_grid_height == '0) begin
            h_last = '0;
        end else if (32'(r_grid_height) > 32'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(r_grid_height - GW'(1));
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. S1 holds the accepted sample and walks through its
    // pending jobs, one per cycle while S2 can take one; S2 holds the differences, S3 the products and
    // S4 is the output register. Each stage fills when the next one is empty or
    // moving, so a bubble anywhere is absorbed and the input side keeps taking
    // beats while a finished result waits.
    // ------------------------------------------------------------------
    logic            r_s1_valid;
    logic [NJOB-1:0] r_s1_pend;
    logic [CW-1:0]   r_s1_col;
    logic [RW-1:0]   r_s1_row;
    logic [WW-1:0]   r_s1_in;

    logic            r_s2_valid;
    logic            r_s3_valid;
    logic            r_s4_valid;

    logic            s2_take;
    logic            s3_take;
    logic            s4_take;
    logic            s1_send;
    logic            s1_single;
    logic            s1_retire;
    logic            in_ready;
    logic            accept;

    assign s4_take   = !r_s4_valid || o_res.ready;
    assign s3_take   = !r_s3_valid || s4_take;
    assign s2_take   = !r_s2_valid || s3_take;
    assign s1_single = (r_s1_pend & (r_s1_pend - NJOB'(1))) == '0;
    assign s1_send   = r_s1_valid && (r_s1_pend != '0) && s2_take;
    assign s1_retire = r_s1_valid && ((r_s1_pend == '0) || (s1_single && s2_take));
    assign in_ready  = !r_s1_valid || s1_retire;
    assign accept    = i_vel.valid && in_ready;

    assign i_vel.ready = in_ready;

    // ------------------------------------------------------------------
    // Raster position of the next sample
    // ------------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic          col_eq_last;
    logic          row_eq_last;

    // Fall back to the frame origin if the position lies outside the grid.
    always_comb begin
        if (r_col > w_last || r_row > h_last) begin
            cur_col = '0;
            cur_row = '0;
        end else begin
            cur_col = r_col;
            cur_row = r_row;
        end
    end

    assign col_eq_last = (cur_col == w_last);
    assign row_eq_last = (cur_row == h_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_eq_last) begin
                r_col <= '0;
                r_row <= row_eq_last ? '0 : cur_row + RW'(1);
            end else begin
                r_col <= cur_col + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: {u, v} words. At the input beat, write the sample and read
    // port A at the row above, one column to the right (clamped), and port B at
    // two rows up in this column - the entry the write replaces, so the store
    // must hand back the old word.
    // ------------------------------------------------------------------
    function automatic logic [AW-1:0] slot(input logic half, input logic [CW-1:0] col);
        slot = AW'(col) + (half ? AW'(MAX_WIDTH) : AW'(0));
    endfunction

    logic [WW-1:0] in_word;
    logic [CW-1:0] rd_col_a;
    logic [WW-1:0] q_right;
    logic [WW-1:0] q_top2;

    assign in_word  = {i_vel.u_velocity, i_vel.v_velocity};
    assign rd_col_a = col_eq_last ? cur_col : cur_col + CW'(1);

    vcds_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (slot(cur_row[0], cur_col)),
        .i_wdata   (in_word),
        .i_re      (accept),
        .i_raddr_a (slot(~cur_row[0], rd_col_a)),
        .i_raddr_b (slot(cur_row[0], cur_col)),
        .o_rdata_a (q_right),
        .o_rdata_b (q_top2)
    );

    // ------------------------------------------------------------------
    // Stage 1: sample register, job mask and the neighbour window
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_pend  <= '0;
        end else if (accept) begin
            r_s1_valid            <= 1'b1;
            r_s1_pend[JOB_UPPER]  <= (cur_row != '0);
            r_s1_pend[JOB_TRAIL]  <= row_eq_last && (cur_col != '0);
            r_s1_pend[JOB_CORNER] <= row_eq_last && col_eq_last;
        end else if (s1_retire) begin
            r_s1_valid <= 1'b0;
            r_s1_pend  <= '0;
        end else if (s1_send) begin
            // drop the job just handed on: the lowest set bit
            r_s1_pend <= r_s1_pend & (r_s1_pend - NJOB'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col <= cur_col;
            r_s1_row <= cur_row;
            r_s1_in  <= in_word;
        end
    end

    // Window on the row above: port A of the previous two samples gives that row at
    // this column and one to the left. Column 0 of the row above is never fetched
    // by port A, so keep it aside as each row starts.
    logic [WW-1:0] r_q1;
    logic [WW-1:0] r_q2;
    logic [WW-1:0] r_c1;
    logic [WW-1:0] r_c2;
    logic [WW-1:0] r_c0_prev;
    logic [WW-1:0] r_c0_cur;

    always_ff @(posedge i_clk) begin
        if (s1_retire) begin
            r_q1 <= q_right;
            r_q2 <= r_q1;
            r_c1 <= r_s1_in;
            r_c2 <= r_c1;
        end
        if (accept && cur_col == '0) begin
            r_c0_prev <= r_c0_cur;
            r_c0_cur  <= in_word;
        end
    end

    // Job operands. Above the sample: pl is the row above at column x-1 (clamped),
    // px the row above at column x.
    logic          s1_x_zero;
    logic          s1_x_le1;
    logic          s1_y_ge1;
    logic          s1_y_ge2;
    logic [WW-1:0] pl;
    logic [WW-1:0] px;
    logic [WW-1:0] op_left;
    logic [WW-1:0] op_right;
    logic [WW-1:0] op_top;
    logic [WW-1:0] op_bot;
    logic [CW-1:0] job_col;
    logic [RW-1:0] job_row;
    logic          job_last;

    assign s1_x_zero = (r_s1_col == '0);
    assign s1_x_le1  = (r_s1_col >> 1) == '0;
    assign s1_y_ge1  = (r_s1_row != '0);
    assign s1_y_ge2  = (r_s1_row >> 1) != '0;
    assign pl        = s1_x_le1  ? r_c0_prev : r_q2;
    assign px        = s1_x_zero ? r_c0_prev : r_q1;

    always_comb begin
        if (r_s1_pend[JOB_UPPER]) begin
            // point one row up: its lower neighbour is the sample itself
            op_left  = pl;
            op_right = q_right;
            op_top   = s1_y_ge2 ? q_top2 : px;
            op_bot   = r_s1_in;
            job_col  = r_s1_col;
            job_row  = r_s1_row - RW'(1);
            job_last = 1'b0;
        end else if (r_s1_pend[JOB_TRAIL]) begin
            // last row, one column to the left: below clamps to the point itself
            op_left  = s1_x_le1 ? r_c1 : r_c2;
            op_right = r_s1_in;
            op_top   = s1_y_ge1 ? pl : r_c1;
            op_bot   = r_c1;
            job_col  = r_s1_col - CW'(1);
            job_row  = r_s1_row;
            job_last = 1'b0;
        end else begin
            // final point of the frame: right and below clamp to the sample
            op_left  = s1_x_zero ? r_s1_in : r_c1;
            op_right = r_s1_in;
            op_top   = s1_y_ge1 ? q_right : r_s1_in;
            op_bot   = r_s1_in;
            job_col  = r_s1_col;
            job_row  = r_s1_row;
            job_last = 1'b1;
        end
    end

    function automatic logic signed [DW-1:0] vdiff(input logic [VW-1:0] a,
                                                   input logic [VW-1:0] b);
        vdiff = $signed({a[VW-1], a}) - $signed({b[VW-1], b});
    endfunction

    // ------------------------------------------------------------------
    // Stage 2: central differences
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_s2_dvx;
    logic signed [DW-1:0] r_s2_duy;
    logic signed [DW-1:0] r_s2_dux;
    logic signed [DW-1:0] r_s2_dvy;
    logic [CW-1:0]        r_s2_col;
    logic [RW-1:0]        r_s2_row;
    logic                 r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_take) begin
            r_s2_valid <= s1_send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take) begin
            r_s2_dvx  <= vdiff(op_right[VW-1:0],  op_left[VW-1:0]);
            r_s2_dux  <= vdiff(op_right[WW-1:VW], op_left[WW-1:VW]);
            r_s2_duy  <= vdiff(op_bot[WW-1:VW],   op_top[WW-1:VW]);
            r_s2_dvy  <= vdiff(op_bot[VW-1:0],    op_top[VW-1:0]);
            r_s2_col  <= job_col;
            r_s2_row  <= job_row;
            r_s2_last <= job_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale by the reciprocal spacings (exact Q.24 products)
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_s3_pvx;
    logic signed [PW-1:0] r_s3_puy;
    logic signed [PW-1:0] r_s3_pux;
    logic signed [PW-1:0] r_s3_pvy;
    logic [CW-1:0]        r_s3_col;
    logic [RW-1:0]        r_s3_row;
    logic                 r_s3_last;
    logic signed [PW-1:0] sx_ext;
    logic signed [PW-1:0] sy_ext;

    assign sx_ext = PW'($signed({1'b0, r_scale_x}));
    assign sy_ext = PW'($signed({1'b0, r_scale_y}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_take) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_take) begin
            r_s3_pvx  <= PW'(r_s2_dvx) * sx_ext;
            r_s3_pux  <= PW'(r_s2_dux) * sx_ext;
            r_s3_puy  <= PW'(r_s2_duy) * sy_ext;
            r_s3_pvy  <= PW'(r_s2_dvy) * sy_ext;
            r_s3_col  <= r_s2_col;
            r_s3_row  <= r_s2_row;
            r_s3_last <= r_s2_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: combine, round half up to Q.8, hold in the output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0]            sum_vort;
    logic signed [SW-1:0]            sum_div;
    logic signed [vcds_pkg::RES_W-1:0] r_s4_vort;
    logic signed [vcds_pkg::RES_W-1:0] r_s4_div;
    logic [vcds_pkg::COORD_W-1:0]    r_s4_col;
    logic [vcds_pkg::COORD_W-1:0]    r_s4_row;
    logic                            r_s4_last;

    assign sum_vort = SW'(r_s3_pvx) - SW'(r_s3_puy) + SW'(vcds_pkg::ROUND_BIAS);
    assign sum_div  = SW'(r_s3_pux) + SW'(r_s3_pvy) + SW'(vcds_pkg::ROUND_BIAS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (s4_take) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_take) begin
            r_s4_vort <= sum_vort[SW-1:vcds_pkg::FRAC_SH];
            r_s4_div  <= sum_div[SW-1:vcds_pkg::FRAC_SH];
            r_s4_col  <= vcds_pkg::COORD_W'(r_s3_col);
            r_s4_row  <= vcds_pkg::COORD_W'(r_s3_row);
            r_s4_last <= r_s3_last;
        end
    end

    assign o_res.valid      = r_s4_valid;
    assign o_res.vorticity  = r_s4_vort;
    assign o_res.divergence = r_s4_div;
    assign o_res.column     = r_s4_col;
    assign o_res.row        = r_s4_row;
    assign o_res.frame_last = r_s4_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pend_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_pend != '0) |-> r_s1_valid)
        else $error("jobs pending with no sample held in stage 1");

    a_col_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !size_wr && !col_eq_last) |=> (r_col == $past(cur_col) + CW'(1)))
        else $error("column counter did not advance on an input beat");

    a_send_fills_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_send |=> r_s2_valid)
        else $error("job handed on from stage 1 was lost");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_s2_valid && !r_s3_valid && !r_s4_valid))
        else $error("pipeline not empty after reset");

endmodule

>>> sim/vcds_stencil_checker.sv
// Checks every result beat of the stencil against a cycle-free prediction of the velocity stream.
`timescale 1ns / 1ps
module vcds_stencil_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [vcds_pkg::APB_AW-1:0] i_paddr,
    input  logic [vcds_pkg::APB_DW-1:0] i_pwdata,
    vcds_in_if                          i_vel,
    vcds_out_if                         i_res,
    output int unsigned                 o_fail_count,
    output int unsigned                 o_outstanding
);
    import vcds_pkg::*;

    localparam int unsigned MAXW = MAX_WIDTH_DEF;
    localparam int unsigned MAXH = MAX_HEIGHT_DEF;

    typedef struct packed {
        logic signed [RES_W-1:0] vorticity;
        logic signed [RES_W-1:0] divergence;
        logic [COORD_W-1:0]      column;
        logic [COORD_W-1:0]      row;
        logic                    frame_last;
    } grid_point_t;

    // Shadow registers and raster position
    logic [GRID_W-1:0]  width_reg;
    logic [GRID_W-1:0]  height_reg;
    logic [SCALE_W-1:0] scale_x_reg;
    logic [SCALE_W-1:0] scale_y_reg;
    int unsigned        col_pos;
    int unsigned        row_pos;

    // Two rows of samples; row r lives in half (r & 1)
    logic signed [VEL_W-1:0] u_rows [2*MAXW];
    logic signed [VEL_W-1:0] v_rows [2*MAXW];

    grid_point_t expected_points [$];
    int unsigned mismatches = 0;

    function automatic int unsigned effective_size(input logic [GRID_W-1:0] v,
                                                   input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned line_slot(input int unsigned r, input int unsigned c);
        return (r & 1) * MAXW + c;
    endfunction

    function automatic int u_at(input int unsigned r, input int unsigned c);
        return u_rows[line_slot(r, c)];
    endfunction

    function automatic int v_at(input int unsigned r, input int unsigned c);
        return v_rows[line_slot(r, c)];
    endfunction

    // Exact Q.24 sums, then one rounding to Q.8 (add half, floor)
    function automatic grid_point_t gradient_point(input int vl, input int vr, input int ul,
                                                   input int ur, input int ut, input int ub,
                                                   input int vt, input int vb,
                                                   input int unsigned c, input int unsigned r,
                                                   input bit last);
        grid_point_t p;
        longint curl_q24, div_q24, curl_q8, div_q8;
        curl_q24 = longint'(vr - vl) * longint'(scale_x_reg)
                 - longint'(ub - ut) * longint'(scale_y_reg);
        div_q24  = longint'(ur - ul) * longint'(scale_x_reg)
                 + longint'(vb - vt) * longint'(scale_y_reg);
        curl_q8 = (curl_q24 + ROUND_BIAS) >>> FRAC_SH;
        div_q8  = (div_q24 + ROUND_BIAS) >>> FRAC_SH;
        p.vorticity  = curl_q8[RES_W-1:0];
        p.divergence = div_q8[RES_W-1:0];
        p.column     = c[COORD_W-1:0];
        p.row        = r[COORD_W-1:0];
        p.frame_last = last;
        return p;
    endfunction

    function automatic grid_point_t stored_point(input int unsigned c, input int unsigned r,
                                                 input int unsigned w, input int unsigned h,
                                                 input bit last);
        int unsigned lft, rgt, up, dn;
        lft = (c > 0) ? c - 1 : 0;
        rgt = (c + 1 < w) ? c + 1 : w - 1;
        up  = (r > 0) ? r - 1 : 0;
        dn  = (r + 1 < h) ? r + 1 : h - 1;
        return gradient_point(v_at(r, lft), v_at(r, rgt), u_at(r, lft), u_at(r, rgt),
                              u_at(up, c), u_at(dn, c), v_at(up, c), v_at(dn, c),
                              c, r, last);
    endfunction

    // Queue every point that the sample completes, in emission order
    function automatic void predict_sample(input logic signed [VEL_W-1:0] u_in,
                                           input logic signed [VEL_W-1:0] v_in);
        int unsigned w, h, x, y, lft, rgt, up;
        int uin, vin;
        w = effective_size(width_reg, MAXW);
        h = effective_size(height_reg, MAXH);
        x = col_pos;
        y = row_pos;
        uin = u_in;
        vin = v_in;
        if (x >= w || y >= h) begin
            x = 0;
            y = 0;
        end
        if (y >= 1) begin
            lft = (x > 0) ? x - 1 : 0;
            rgt = (x + 1 < w) ? x + 1 : w - 1;
            up  = (y >= 2) ? y - 2 : 0;
            expected_points.push_back(gradient_point(
                v_at(y - 1, lft), v_at(y - 1, rgt), u_at(y - 1, lft), u_at(y - 1, rgt),
                u_at(up, x), uin, v_at(up, x), vin, x, y - 1, 1'b0));
        end
        u_rows[line_slot(y, x)] = u_in;
        v_rows[line_slot(y, x)] = v_in;
        if (y == h - 1) begin
            if (x >= 1) expected_points.push_back(stored_point(x - 1, y, w, h, 1'b0));
            if (x == w - 1) expected_points.push_back(stored_point(x, y, w, h, 1'b1));
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endfunction

    always @(posedge i_clk) begin
        grid_point_t want;
        if (!i_rst_n) begin
            width_reg   = GRID_WIDTH_RST;
            height_reg  = GRID_HEIGHT_RST;
            scale_x_reg = SCALE_X_RST;
            scale_y_reg = SCALE_Y_RST;
            col_pos     = 0;
            row_pos     = 0;
            expected_points.delete();
        end else begin
            // Compare before predicting so a fresh sample can never excuse a stray beat
            if (i_res.valid && i_res.ready) begin
                if (expected_points.size() == 0) begin
                    $error("result beat at column %0d row %0d with nothing expected",
                           i_res.column, i_res.row);
                    mismatches++;
                end else begin
                    want = expected_points.pop_front();
                    if (i_res.vorticity !== want.vorticity) begin
                        $error("vorticity: expected %0d, got %0d",
                               want.vorticity, i_res.vorticity);
                        mismatches++;
                    end
                    if (i_res.divergence !== want.divergence) begin
                        $error("divergence: expected %0d, got %0d",
                               want.divergence, i_res.divergence);
                        mismatches++;
                    end
                    if (i_res.column !== want.column) begin
                        $error("column: expected %0d, got %0d", want.column, i_res.column);
                        mismatches++;
                    end
                    if (i_res.row !== want.row) begin
                        $error("row: expected %0d, got %0d", want.row, i_res.row);
                        mismatches++;
                    end
                    if (i_res.frame_last !== want.frame_last) begin
                        $error("frame_last: expected %0d, got %0d",
                               want.frame_last, i_res.frame_last);
                        mismatches++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_GRID_WIDTH: begin
                        width_reg = i_pwdata[GRID_W-1:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    REG_GRID_HEIGHT: begin
                        height_reg = i_pwdata[GRID_W-1:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    REG_SCALE_X: scale_x_reg = i_pwdata[SCALE_W-1:0];
                    REG_SCALE_Y: scale_y_reg = i_pwdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (i_vel.valid && i_vel.ready) predict_sample(i_vel.u_velocity, i_vel.v_velocity);
        end
        o_outstanding <= expected_points.size();
        o_fail_count  <= mismatches;
    end

endmodule

>>> sim/tb_velocity_curl_divergence_stencil.sv
// Testbench top: clock, reset, register writes, velocity stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps
module tb_velocity_curl_divergence_stencil;
    import vcds_pkg::*;

    // Hard limit on the run, set well above the slowest plausible run.
    localparam int unsigned CYCLE_LIMIT     = 500000;
    // Pipe is four deep; the settle time lets it finish samples that emit nothing.
    localparam int unsigned SETTLE_CYCLES   = 12;
    localparam int unsigned HOLD_OFF_CYCLES = 200;

    localparam logic signed [VEL_W-1:0] VEL_MAX   = 16'sh7FFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN   = 16'sh8000;
    localparam logic [SCALE_W-1:0]      SCALE_MAX = {SCALE_W{1'b1}};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycle_count       = 0;
    int unsigned send_gap_pct      = 21;
    int unsigned recv_stall_pct    = 48;
    int unsigned hold_off_requests = 0;

    vcds_in_if  vel_if ();
    vcds_out_if res_if ();

    velocity_curl_divergence_stencil dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_vel   (vel_if),
        .o_res   (res_if)
    );

    vcds_stencil_checker point_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_vel         (vel_if),
        .i_res         (res_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side. Stall at the current rate, or hold ready low for a long
    // stretch whenever the stimulus asks for one; the stretch is counted here
    // so the sender keeps pushing samples into the filling pipe meanwhile.
    initial begin
        int unsigned hold_offs_served;
        hold_offs_served = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_offs_served != hold_off_requests) begin
                hold_offs_served++;
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic signed [VEL_W-1:0] random_velocity();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return VEL_MIN;
            1:       return VEL_MAX;
            default: return r[VEL_W-1:0];
        endcase
    endfunction

    // Mostly moderate reciprocals, with zero, one, full scale and raw noise mixed in
    function automatic logic [SCALE_W-1:0] pick_scale();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return '0;
            1:       return SCALE_MAX;
            2:       return 1;
            3:       return r[SCALE_W-1:0];
            default: return $urandom_range(1024, 131072);
        endcase
    endfunction

    // Offer one sample and hold it until it is taken. Valid is left high on
    // return so back-to-back beats never drop it within a time step.
    task automatic send_sample(input logic signed [VEL_W-1:0] u, input logic signed [VEL_W-1:0] v);
        if ($urandom_range(99) < send_gap_pct) begin
            vel_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        vel_if.valid      <= 1'b1;
        vel_if.u_velocity <= u;
        vel_if.v_velocity <= v;
        @(posedge clk);
        while (!vel_if.ready) @(posedge clk);
    endtask

    // Stop offering, wait for every expected result, then let the pipe empty
    // of samples that produce no result.
    task automatic settle();
        vel_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup then access; psel stays high so writes can follow back to back.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    // Size writes restart the frame; scale-only updates let it carry on.
    task automatic configure(input bit resize, input int unsigned w, input int unsigned h,
                             input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy);
        settle();
        if (resize) begin
            write_reg(REG_GRID_WIDTH, w);
            write_reg(REG_GRID_HEIGHT, h);
        end
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Small grids keep results dense: whole frames with random content, now and
    // then a frame cut short, and sometimes a scale change in mid-frame.
    task automatic random_traffic(input int unsigned target);
        int unsigned sent, w, h, burst;
        bit resize;
        sent = 0;
        w = 3;
        h = 3;
        while (sent < target) begin
            resize = (sent == 0) || ($urandom_range(3) != 0);
            if (resize) begin
                w = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                h = $urandom_range(1, 5);
            end
            configure(resize, w, h, pick_scale(), pick_scale());
            burst = w * h * $urandom_range(1, 2);
            if ($urandom_range(3) == 0) burst = $urandom_range(1, burst);
            repeat (burst) send_sample(random_velocity(), random_velocity());
            sent += burst;
        end
    endtask

    initial begin
        int unsigned k;

        // Every input known from the first instant, with reset held asserted at the start.
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        vel_if.valid      <= 1'b0;
        vel_if.u_velocity <= '0;
        vel_if.v_velocity <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: three by three grid at full scale. The centre sees the
        // largest swings in every direction; the rim exercises edge clamping.
        configure(1'b1, 3, 3, SCALE_MAX, SCALE_MAX);
        for (k = 0; k < 9; k++) begin
            case (k)
                0: send_sample(16'sd0, -16'sd1);
                1: send_sample(VEL_MAX, VEL_MIN);
                2: send_sample(16'sd1, VEL_MAX);
                3: send_sample(VEL_MIN, VEL_MIN);
                4: send_sample(-16'sd1, 16'sd0);
                5: send_sample(VEL_MAX, VEL_MAX);
                6: send_sample(VEL_MAX, VEL_MIN);
                7: send_sample(VEL_MIN, VEL_MAX);
                default: send_sample(-16'sd2, 16'sd2);
            endcase
        end

        // Zero sizes collapse to a single point: every sample is a whole frame.
        configure(1'b1, 0, 0, '0, 1);
        send_sample(VEL_MIN, VEL_MAX);
        send_sample(VEL_MAX, VEL_MIN);
        send_sample(16'sd0, 16'sd0);

        // Two by two with one scale at zero.
        configure(1'b1, 2, 2, 1, '0);
        send_sample(VEL_MIN, VEL_MAX);
        send_sample(VEL_MAX, VEL_MIN);
        send_sample(VEL_MAX, VEL_MIN);
        send_sample(VEL_MIN, VEL_MAX);

        // Oversize writes saturate: one full row of the widest grid, then one
        // full column of the tallest, so the far edge clamps are reached.
        configure(1'b1, 2047, 1, pick_scale(), pick_scale());
        repeat (1024) send_sample(random_velocity(), random_velocity());
        configure(1'b1, 1, 2047, pick_scale(), pick_scale());
        repeat (1024) send_sample(random_velocity(), random_velocity());

        // Random traffic, sender idling less than the receiver stalls.
        random_traffic(77);

        // Swap the idling rates.
        settle();
        send_gap_pct   = 48;
        recv_stall_pct = 21;
        random_traffic(77);

        // No idling. First block the result side for a long stretch while
        // whole frames keep arriving, so the input backs up behind it.
        settle();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        configure(1'b1, 4, 3, pick_scale(), pick_scale());
        hold_off_requests++;
        repeat (24) send_sample(random_velocity(), random_velocity());
        random_traffic(55);

        // Drain and give the verdict.
        settle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
